// File: rtl/imt_pkg.sv
`default_nettype none

package imt_pkg;

  // Default table geometry
  localparam int SLOTS_DEF         = 8;
  localparam int PAYLOAD_BYTES_DEF = 64;

  // Field widths
  localparam int CMD_W   = 4;
  localparam int ID_W    = 16;
  localparam int DST_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int LEN_W   = 8;
  localparam int OFF_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int STAGE_W = 2;
  localparam int DUE_W   = 2;

  // Beat widths
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 56;

  // Timeout reset values
  localparam logic [TIME_W-1:0] FIRST_TMO_RST  = 32'd1000;
  localparam logic [TIME_W-1:0] SECOND_TMO_RST = 32'd5000;

  // Configuration register indexes
  localparam logic REG_FIRST_TMO  = 1'b0;
  localparam logic REG_SECOND_TMO = 1'b1;

  // Slot stages
  localparam logic [STAGE_W-1:0] STAGE_EMPTY  = 2'd0;
  localparam logic [STAGE_W-1:0] STAGE_FIRST  = 2'd1;
  localparam logic [STAGE_W-1:0] STAGE_SECOND = 2'd2;

  // Due actions
  localparam logic [DUE_W-1:0] ACT_NONE     = 2'd0;
  localparam logic [DUE_W-1:0] ACT_FALLBACK = 2'd1;
  localparam logic [DUE_W-1:0] ACT_FAILURE  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 4'd0,
    CMD_FIND       = 4'd1,
    CMD_CLEAR      = 4'd2,
    CMD_PROMOTE    = 4'd3,
    CMD_RELEASE    = 4'd4,
    CMD_DUE        = 4'd5,
    CMD_READ_SLOT  = 4'd6,
    CMD_WRITE_BYTE = 4'd7,
    CMD_READ_BYTE  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/imt_ram.sv
`default_nettype none

module imt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/inflight_message_table_core.sv
// Sequence: add, find and clear scan one slot per cycle in ST_SCAN, a hit then
//   passing ST_EXEC and ST_RESP, a miss only ST_RESP; slot, due, read and byte
//   commands pass ST_EXEC and ST_RESP, a rejected add or unknown command ST_RESP.
// Throughput: one command at a time; ST_RESP waits for a free output register.
// Reset (rst_n, synchronous, active low) empties all slots, zeroes their
//   fields and restores the timeouts; the payload memory is not cleared.
`default_nettype none

module inflight_message_table_core
  import imt_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command input
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // msg_id, destination, slot, payload_len, byte_offset, byte_in, now, pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic [CMD_W-1:0]      in_tuser,
  // result output
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // slot_out, stage_out, due_action, msg_id_out, destination_out,
  // payload_len_out, byte_out
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // ok
  output logic                       out_tuser,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [TIME_W-1:0]     cfg_data
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH  = SLOTS * PAYLOAD_BYTES;
  localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Unpacked input fields
  logic [ID_W-1:0]   in_id;
  logic [DST_W-1:0]  in_dst;
  logic [SLOT_W-1:0] in_slot;
  logic [LEN_W-1:0]  in_len;
  logic [OFF_W-1:0]  in_off;
  logic [BYTE_W-1:0] in_byte;
  logic [TIME_W-1:0] in_now;

  assign in_id   = in_tdata[15:0];
  assign in_dst  = in_tdata[31:16];
  assign in_slot = in_tdata[35:32];
  assign in_len  = in_tdata[43:36];
  assign in_off  = in_tdata[51:44];
  assign in_byte = in_tdata[59:52];
  assign in_now  = in_tdata[91:60];

  // Sequencer and command registers
  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [DST_W-1:0]  dst_r, dst_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic              ok_r, ok_nxt;
  logic [DUE_W-1:0]  due_r, due_nxt;

  // Timeouts
  logic [TIME_W-1:0] tmo1_r, tmo1_nxt;
  logic [TIME_W-1:0] tmo2_r, tmo2_nxt;

  // Slot table
  logic [STAGE_W-1:0] slot_stage_r [SLOTS];
  logic [STAGE_W-1:0] slot_stage_nxt [SLOTS];
  logic [ID_W-1:0]    slot_id_r [SLOTS];
  logic [ID_W-1:0]    slot_id_nxt [SLOTS];
  logic [DST_W-1:0]   slot_dst_r [SLOTS];
  logic [DST_W-1:0]   slot_dst_nxt [SLOTS];
  logic [LEN_W-1:0]   slot_len_r [SLOTS];
  logic [LEN_W-1:0]   slot_len_nxt [SLOTS];
  logic [TIME_W-1:0]  slot_ts_r [SLOTS];
  logic [TIME_W-1:0]  slot_ts_nxt [SLOTS];

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_ok_r, out_ok_nxt;

  // Payload memory port
  logic              ram_en, ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  // Shared datapath on the slot under the pointer
  logic [IDX_W-1:0]  idx;
  logic              slot_ok, byte_ok, last_slot, scan_hit;
  logic [TIME_W-1:0] elapsed;
  logic [STAGE_W-1:0] cur_stage;

  assign idx       = ptr_r[IDX_W-1:0];
  assign slot_ok   = {1'b0, ptr_r} < (SLOT_W + 1)'(SLOTS);
  assign byte_ok   = off_r < LEN_W'(PAYLOAD_BYTES);
  assign last_slot = {1'b0, ptr_r} == (SLOT_W + 1)'(SLOTS - 1);
  assign cur_stage = slot_stage_r[idx];
  assign elapsed   = now_r - slot_ts_r[idx];
  assign scan_hit  = (cmd_r == CMD_ADD) ? (cur_stage == STAGE_EMPTY)
                   : ((cur_stage != STAGE_EMPTY) && (slot_id_r[idx] == id_r));
  assign ram_addr  = MEM_AW'(idx) * MEM_AW'(PAYLOAD_BYTES) + MEM_AW'(off_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, table updates and result
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    dst_nxt        = dst_r;
    len_nxt        = len_r;
    off_nxt        = off_r;
    byte_nxt       = byte_r;
    now_nxt        = now_r;
    ptr_nxt        = ptr_r;
    ok_nxt         = ok_r;
    due_nxt        = due_r;
    tmo1_nxt       = tmo1_r;
    tmo2_nxt       = tmo2_r;
    slot_stage_nxt = slot_stage_r;
    slot_id_nxt    = slot_id_r;
    slot_dst_nxt   = slot_dst_r;
    slot_len_nxt   = slot_len_r;
    slot_ts_nxt    = slot_ts_r;
    out_data_nxt   = out_data_r;
    out_ok_nxt     = out_ok_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_en         = 1'b0;
    ram_we         = 1'b0;

    // configuration writes
    if (cfg_we) begin
      if (cfg_index == REG_FIRST_TMO) begin
        tmo1_nxt = cfg_data;
      end else begin
        tmo2_nxt = cfg_data;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = in_tuser;
          id_nxt   = in_id;
          dst_nxt  = in_dst;
          len_nxt  = in_len;
          off_nxt  = in_off;
          byte_nxt = in_byte;
          now_nxt  = in_now;
          ok_nxt   = 1'b0;
          due_nxt  = ACT_NONE;
          if (in_tuser == CMD_ADD) begin
            ptr_nxt   = '0;
            state_nxt = (in_len > LEN_W'(PAYLOAD_BYTES)) ? ST_RESP : ST_SCAN;
          end else if (in_tuser inside {CMD_FIND, CMD_CLEAR}) begin
            ptr_nxt   = '0;
            state_nxt = ST_SCAN;
          end else if (in_tuser inside {[CMD_PROMOTE:CMD_READ_BYTE]}) begin
            ptr_nxt   = in_slot;
            state_nxt = ST_EXEC;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      // one slot per cycle through the shared compare
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = ST_EXEC;
        end else if (last_slot) begin
          state_nxt = ST_RESP;
        end else begin
          ptr_nxt = ptr_r + SLOT_W'(1);
        end
      end

      ST_EXEC: begin
        state_nxt = ST_RESP;
        case (cmd_r)
          CMD_ADD: begin
            slot_id_nxt[idx]    = id_r;
            slot_dst_nxt[idx]   = dst_r;
            slot_len_nxt[idx]   = len_r;
            slot_ts_nxt[idx]    = now_r;
            slot_stage_nxt[idx] = STAGE_FIRST;
            ok_nxt              = 1'b1;
          end
          CMD_FIND: begin
            ok_nxt = 1'b1;
          end
          CMD_CLEAR: begin
            slot_stage_nxt[idx] = STAGE_EMPTY;
            ok_nxt              = 1'b1;
          end
          CMD_PROMOTE: begin
            if (slot_ok) begin
              slot_stage_nxt[idx] = STAGE_SECOND;
              slot_ts_nxt[idx]    = now_r;
            end
            ok_nxt = slot_ok;
          end
          CMD_RELEASE: begin
            if (slot_ok) begin
              slot_stage_nxt[idx] = STAGE_EMPTY;
            end
            ok_nxt = slot_ok;
          end
          CMD_DUE: begin
            if (slot_ok) begin
              if (cur_stage == STAGE_FIRST && elapsed >= tmo1_r) begin
                due_nxt = ACT_FALLBACK;
              end else if (cur_stage == STAGE_SECOND && elapsed >= tmo2_r) begin
                due_nxt = ACT_FAILURE;
              end
            end
            ok_nxt = slot_ok;
          end
          CMD_READ_SLOT: begin
            ok_nxt = slot_ok;
          end
          CMD_WRITE_BYTE: begin
            ram_en = slot_ok && byte_ok;
            ram_we = slot_ok && byte_ok;
            ok_nxt = slot_ok && byte_ok;
          end
          CMD_READ_BYTE: begin
            ram_en = slot_ok && byte_ok;
            ok_nxt = slot_ok && byte_ok;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end

      // load the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          if (ok_r) begin
            out_data_nxt = {
              (cmd_r == CMD_READ_BYTE) ? ram_rdata : BYTE_W'(0),
              slot_len_r[idx],
              slot_dst_r[idx],
              slot_id_r[idx],
              due_r,
              cur_stage,
              ptr_r
            };
          end else begin
            out_data_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control, table and timeout registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tmo1_r      <= FIRST_TMO_RST;
      tmo2_r      <= SECOND_TMO_RST;
      for (int i = 0; i < SLOTS; i++) begin
        slot_stage_r[i] <= STAGE_EMPTY;
        slot_id_r[i]    <= '0;
        slot_dst_r[i]   <= '0;
        slot_len_r[i]   <= '0;
        slot_ts_r[i]    <= '0;
      end
    end else begin
      out_valid_r  <= out_valid_nxt;
      tmo1_r       <= tmo1_nxt;
      tmo2_r       <= tmo2_nxt;
      slot_stage_r <= slot_stage_nxt;
      slot_id_r    <= slot_id_nxt;
      slot_dst_r   <= slot_dst_nxt;
      slot_len_r   <= slot_len_nxt;
      slot_ts_r    <= slot_ts_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    dst_r      <= dst_nxt;
    len_r      <= len_nxt;
    off_r      <= off_nxt;
    byte_r     <= byte_nxt;
    now_r      <= now_nxt;
    ptr_r      <= ptr_nxt;
    ok_r       <= ok_nxt;
    due_r      <= due_nxt;
    out_data_r <= out_data_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  // Payload bytes, one area of PAYLOAD_BYTES per slot
  imt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_payload (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (byte_r),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // one command at a time: no beat right after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while another is in progress");

  // a failed result carries all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed result with nonzero fields");

  // due action only on a successful due command, and stage is never reserved code
  a_due_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] != ACT_NONE |-> out_tuser && out_tdata[5:4] != 2'd3)
    else $error("due action on failed result or bad stage");

  // scan pointer stays inside the table
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> slot_ok)
    else $error("scan pointer beyond table");
`endif

endmodule

`default_nettype wire
